// ----- rtl/core/ssa_pkg.sv -----
`timescale 1ns / 1ps
package ssa_pkg;
	localparam int PageCount = 64;
	localparam int PageW = $clog2(PageCount);
	localparam int PageBytes = 4096;
	localparam int HeaderBytes = 32;
	localparam int NumClasses = 8;
	localparam int SlotW = 8;
	localparam logic [SlotW-1:0] SLOT_NULL = 8'hFF;

	typedef struct packed {
		logic        mode;
		logic [15:0] request_bytes;
		logic [17:0] slot_address;
	} req_t;

	typedef struct packed {
		logic [17:0] granted_address;
		logic [2:0]  size_class;
		logic [2:0]  status;
	} rsp_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_LARGE = 3'd2;
	localparam logic [2:0] ST_NOPAGE = 3'd3;
	localparam logic [2:0] ST_BADFREE = 3'd4;
	localparam logic [2:0] ST_LFREE = 3'd5;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_LOAD, CMD_WALK, CMD_CLAIM, CMD_INIT, CMD_POP, CMD_FREE, CMD_DONE
	} cmd_t;

	typedef struct packed {
		logic walk_hit;    // current walk page has a free slot
		logic walk_end;    // walk reached end of list
		logic pages_full;
		logic init_last;
		logic early_done;  // request resolved without state work
	} stat_t;

	// Per-page record: class, next page in the class list, free chain head
	// and number of slots in use.
	typedef struct packed {
		logic [2:0]       tag;
		logic [PageW:0]   link;
		logic [SlotW-1:0] fhead;
		logic [SlotW-1:0] ucnt;
	} page_rec_t;

	// Slots per page for a class, at most 254.
	function automatic logic [SlotW-1:0] slots_in_page(input logic [2:0] c);
		logic [SlotW-1:0] n;
		case (c)
			3'd0: n = 8'd254;
			3'd1: n = 8'd127;
			3'd2: n = 8'd63;
			3'd3: n = 8'd31;
			3'd4: n = 8'd15;
			3'd5: n = 8'd7;
			3'd6: n = 8'd3;
			default: n = 8'd1;
		endcase
		return n;
	endfunction
endpackage

// ----- rtl/core/ssa_datapath.sv -----
`timescale 1ns / 1ps
module ssa_datapath import ssa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  req_t  req,
	output stat_t stat,
	output rsp_t  rsp
);
	page_rec_t        page_mem [PageCount];
	logic [SlotW-1:0] slink_mem [PageCount*256];
	logic [PageW:0]   chead_q [NumClasses];
	logic [PageW:0]   claimed_q;

	// Registered reads: prec_q holds the page record read at p_q, and slink_rd_q holds
	// the link behind the free head of prec_q.
	page_rec_t        prec_q;
	logic [SlotW-1:0] slink_rd_q;
	logic [2:0]       cls_q;
	logic [PageW:0]   p_q;
	logic [PageW:0]   steps_q;
	logic [SlotW-1:0] idx_q;
	logic [11:0]      off_q;
	logic             early_q;
	rsp_t             rsp_q;

	logic [2:0]       cls_c;
	logic             big_c;
	logic [PageW-1:0] pi;
	logic [11:0]      off;
	logic [PageW:0]   fpage;
	logic             fpage_ok;
	logic [11:0]      rel;
	logic [2:0]       tcls;
	logic [SlotW-1:0] fslot;
	logic             free_ok_c;

	always_comb begin
		big_c = 1'b1;
		cls_c = 3'd0;
		for (int c = NumClasses-1; c >= 0; c--)
			if ({1'b0, req.request_bytes} <= (17'd16 << c)) begin
				cls_c = 3'(c);
				big_c = 1'b0;
			end
		pi = p_q[PageW-1:0];
		off = req.slot_address[11:0];
		fpage = (PageW+1)'(req.slot_address[17:12]);
		// Pages are claimed in ascending order, so a page below the claim
		// count always carries a class.
		fpage_ok = fpage < claimed_q;
		tcls = prec_q.tag;
		rel = off_q - 12'(HeaderBytes);
		fslot = 8'(rel >> (4 + tcls));
		free_ok_c = (off_q >= 12'(HeaderBytes))
			&& ((rel & ((12'd16 << tcls) - 12'd1)) == 12'd0)
			&& (fslot < slots_in_page(tcls)) && (prec_q.ucnt != 8'd0);
	end

	assign stat.walk_hit = prec_q.fhead != SLOT_NULL;
	assign stat.walk_end = (p_q >= (PageW+1)'(PageCount)) || (steps_q >= (PageW+1)'(PageCount));
	assign stat.pages_full = claimed_q >= (PageW+1)'(PageCount);
	assign stat.init_last = (idx_q + 8'd1) >= slots_in_page(cls_q);
	assign stat.early_done = early_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
			for (int i = 0; i < NumClasses; i++) chead_q[i] <= '1;
		end else begin
			case (cmd)
				CMD_CLAIM: begin
					chead_q[cls_q] <= claimed_q;
					claimed_q <= claimed_q + (PageW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prec_q <= page_mem[pi];
		slink_rd_q <= slink_mem[{pi, prec_q.fhead}];
		case (cmd)
			CMD_LOAD: begin
				steps_q <= '0;
				off_q <= off;
				rsp_q.granted_address <= '0;
				rsp_q.size_class <= 3'd0;
				if (req.mode) begin
					p_q <= fpage;
					rsp_q.status <= (off == 12'd8) ? ST_LFREE : ST_BADFREE;
					early_q <= (off == 12'd8) || !fpage_ok;
				end else begin
					cls_q <= cls_c;
					p_q <= chead_q[cls_c];
					rsp_q.status <= (req.request_bytes == 16'd0) ? ST_ZERO : ST_LARGE;
					early_q <= (req.request_bytes == 16'd0) || big_c;
				end
			end
			CMD_WALK: begin
				p_q <= prec_q.link;
				steps_q <= steps_q + (PageW+1)'(1);
			end
			CMD_CLAIM: begin
				p_q <= claimed_q;
				steps_q <= '0;
				idx_q <= '0;
				page_mem[claimed_q[PageW-1:0]] <= '{tag: cls_q, link: chead_q[cls_q],
					fhead: slots_in_page(cls_q) - 8'd1, ucnt: 8'd0};
			end
			CMD_INIT: begin
				slink_mem[{pi, idx_q}] <= (idx_q == 8'd0) ? SLOT_NULL : idx_q - 8'd1;
				idx_q <= idx_q + 8'd1;
			end
			CMD_POP: begin
				page_mem[pi] <= '{tag: prec_q.tag, link: prec_q.link,
					fhead: slink_rd_q, ucnt: prec_q.ucnt + 8'd1};
				rsp_q.size_class <= cls_q;
				rsp_q.status <= ST_OK;
				rsp_q.granted_address <= 18'(({12'd0, pi} << 12) + 18'(HeaderBytes)
					+ (18'(prec_q.fhead) << (4 + cls_q)));
			end
			CMD_FREE: begin
				rsp_q.size_class <= tcls;
				if (free_ok_c) begin
					slink_mem[{pi, fslot}] <= prec_q.fhead;
					page_mem[pi] <= '{tag: prec_q.tag, link: prec_q.link,
						fhead: fslot, ucnt: prec_q.ucnt - 8'd1};
					rsp_q.status <= ST_OK;
				end
			end
			CMD_DONE: begin
				rsp_q.size_class <= cls_q;
				rsp_q.status <= ST_NOPAGE;
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/ssa_ctrl.sv -----
`timescale 1ns / 1ps
module ssa_ctrl import ssa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	input  logic  is_free,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_WALK, S_WAIT, S_INIT, S_POP, S_CHECK, S_OUT
	} state_t;
	state_t state_q;
	logic   free_q;

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_IDLE: if (start) cmd = CMD_LOAD;
			S_WALK: begin
				if (stat.walk_end) cmd = stat.pages_full ? CMD_DONE : CMD_CLAIM;
				else if (!stat.walk_hit) cmd = CMD_WALK;
			end
			S_INIT: cmd = CMD_INIT;
			S_POP: cmd = CMD_POP;
			S_CHECK: cmd = CMD_FREE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
			done <= 1'b0;
			free_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DECIDE;
					busy <= 1'b1;
					free_q <= is_free;
				end
				S_DECIDE: begin
					if (stat.early_done) state_q <= S_OUT;
					else if (free_q) state_q <= S_CHECK;
					else state_q <= S_WALK;
				end
				S_WALK: begin
					if (stat.walk_end) state_q <= stat.pages_full ? S_OUT : S_INIT;
					else if (stat.walk_hit) state_q <= S_POP;
					else state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_WALK;
				S_INIT: if (stat.init_last) state_q <= S_WALK;
				S_POP: state_q <= S_OUT;
				S_CHECK: state_q <= S_OUT;
				S_OUT: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
					done <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start lost");
endmodule

// ----- rtl/core/slab_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
// Slab slot allocator: eight power-of-two slot classes (16 to 2048 bytes)
// over 64 pages of 4 KiB, each with a 32-byte header.
// A transaction is taken at a rising edge with start high and busy low; the
// request struct carries mode, request_bytes and slot_address.
// busy stays high until the response; the response struct is valid for the
// single cycle in which done is high, and the receiver cannot stall it.
// An early rejection (zero size, too large, large-block free, free into an
// unclaimed page) goes from the decide state straight to the output state;
// any other free passes through a check state. An allocation walks its
// class's page list, with a wait state per full page visited, and pops a
// slot from the first page with a free one; claiming a new page first chains
// its slots (up to 254 for the 16-byte class). Running out of pages ends the walk.
// busy falls as done rises, so the next transaction can be accepted at the
// same edge that takes the result.
// Reset clears the class list heads and the claim count at once. A page's
// record and slot links are written when the page is claimed, and pages at
// or past the claim count count as unassigned, so no clearing pass is needed.
module slab_slot_allocator_unit import ssa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);
	cmd_t  cmd;
	stat_t stat;

	ssa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.is_free(req.mode), .cmd(cmd), .busy(busy), .done(done)
	);

	ssa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req), .stat(stat), .rsp(rsp)
	);
endmodule
